### design/grib2_to_grib1_level_map_core_defines.svh
// assertion macros used by the rtl core
`ifndef GRIB2_TO_GRIB1_LEVEL_MAP_CORE_DEFINES_SVH
`define GRIB2_TO_GRIB1_LEVEL_MAP_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define G2G1_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// delayed implication, held off during reset
`define G2G1_ASSERT_LAT(lbl, clk, rstn, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

### design/g2g1lvl_pkg.sv
package g2g1lvl_pkg;

  localparam int unsigned MagW = 32;

  localparam logic [7:0] TypeNone = 8'd255;
  localparam logic [7:0] CodeBad  = 8'd255;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    MODE_ZERO,
    MODE_SINGLE,
    MODE_LAYER,
    MODE_RAW,
    MODE_ISEN,
    MODE_PV,
    MODE_BAD
  } mode_e;

  typedef struct packed {
    logic [7:0]        code;
    mode_e             mode;
    logic signed [4:0] e1;
    logic signed [4:0] e2;
  } dec_t;

  // per-lane scaling control
  typedef struct packed {
    logic       neg;
    logic       up;
    logic       sym;
    logic       far;
    logic       huge;
    logic [3:0] a;
    logic [3:0] b;
  } lane_t;

  function automatic logic [29:0] pow10(logic [3:0] i);
    logic [29:0] r;
    case (i)
      4'd0:    r = 30'd1;
      4'd1:    r = 30'd10;
      4'd2:    r = 30'd100;
      4'd3:    r = 30'd1000;
      4'd4:    r = 30'd10000;
      4'd5:    r = 30'd100000;
      4'd6:    r = 30'd1000000;
      4'd7:    r = 30'd10000000;
      4'd8:    r = 30'd100000000;
      4'd9:    r = 30'd1000000000;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // floor(2^32 / 10^i), low by at most one in the quotient
  function automatic logic [28:0] recip10(logic [3:0] i);
    logic [28:0] r;
    case (i)
      4'd1:    r = 29'd429496729;
      4'd2:    r = 29'd42949672;
      4'd3:    r = 29'd4294967;
      4'd4:    r = 29'd429496;
      4'd5:    r = 29'd42949;
      4'd6:    r = 29'd4294;
      4'd7:    r = 29'd429;
      4'd8:    r = 29'd42;
      4'd9:    r = 29'd4;
      default: r = 29'd0;
    endcase
    return r;
  endfunction

  function automatic lane_t lane_prep(logic signed [4:0] e, logic signed [7:0] s,
                                      logic sym, logic neg);
    lane_t             c;
    logic signed [8:0] k;
    logic [8:0]        m;
    k      = 9'(e) - 9'(s);
    m      = 9'd0 - k;
    c.neg  = neg;
    c.sym  = sym;
    c.up   = !k[8];
    c.far  = 1'b0;
    c.huge = 1'b0;
    c.a    = 4'd0;
    c.b    = 4'd0;
    if (c.up) begin
      if (k > 9'sd18) begin
        c.huge = 1'b1;
      end else if (k > 9'sd9) begin
        c.a = 4'd9;
        c.b = 4'(k - 9'sd9);
      end else begin
        c.a = k[3:0];
      end
    end else begin
      if (m > 9'd9) begin
        c.far = 1'b1;
      end else begin
        c.a = m[3:0];
      end
    end
    return c;
  endfunction

endpackage

### design/g2g1lvl_decode.sv
module g2g1lvl_decode (
  input  logic [7:0]        t1_i,
  input  logic [7:0]        t2_i,
  output g2g1lvl_pkg::dec_t dec_o
);
  import g2g1lvl_pkg::*;

  always_comb begin
    dec_o.code = CodeBad;
    dec_o.mode = MODE_ZERO;
    dec_o.e1   = 5'sd0;
    dec_o.e2   = 5'sd0;
    if (t1_i == 8'd10 && t2_i == TypeNone) begin
      dec_o.code = 8'd200;
    end else if (t1_i < 8'd100 && t2_i == TypeNone) begin
      dec_o.code = t1_i;
    end else if ((t1_i == 8'd1 || t1_i == 8'd2) && t2_i == 8'd8) begin
      dec_o.code = t1_i;
    end else if (t1_i >= 8'd200 && t2_i == TypeNone) begin
      dec_o.code = t1_i;
    end else if (t1_i == 8'd100 && t2_i == TypeNone) begin
      dec_o.code = 8'd100; dec_o.mode = MODE_SINGLE; dec_o.e1 = -5'sd2;
    end else if (t1_i == 8'd100 && t2_i == 8'd100) begin
      dec_o.code = 8'd101; dec_o.mode = MODE_LAYER; dec_o.e1 = -5'sd3; dec_o.e2 = -5'sd3;
    end else if (t1_i == 8'd101 && t2_i == TypeNone) begin
      dec_o.code = 8'd102;
    end else if (t1_i == 8'd102 && t2_i == TypeNone) begin
      dec_o.code = 8'd103; dec_o.mode = MODE_SINGLE;
    end else if (t1_i == 8'd102 && t2_i == 8'd102) begin
      dec_o.code = 8'd104; dec_o.mode = MODE_LAYER; dec_o.e1 = -5'sd2; dec_o.e2 = -5'sd2;
    end else if (t1_i == 8'd103 && t2_i == TypeNone) begin
      dec_o.code = 8'd105; dec_o.mode = MODE_SINGLE;
    end else if (t1_i == 8'd103 && t2_i == 8'd103) begin
      dec_o.code = 8'd106; dec_o.mode = MODE_LAYER; dec_o.e1 = -5'sd2; dec_o.e2 = -5'sd2;
    end else if (t1_i == 8'd104 && t2_i == TypeNone) begin
      dec_o.code = 8'd107; dec_o.mode = MODE_SINGLE; dec_o.e1 = 5'sd4;
    end else if (t1_i == 8'd104 && t2_i == 8'd104) begin
      dec_o.code = 8'd108; dec_o.mode = MODE_LAYER; dec_o.e1 = 5'sd2; dec_o.e2 = 5'sd2;
    end else if (t1_i == 8'd105 && t2_i == TypeNone) begin
      dec_o.code = 8'd109; dec_o.mode = MODE_RAW;
    end else if (t1_i == 8'd105 && t2_i == 8'd105) begin
      dec_o.code = 8'd110; dec_o.mode = MODE_LAYER;
    end else if (t1_i == 8'd106 && t2_i == TypeNone) begin
      dec_o.code = 8'd111; dec_o.mode = MODE_SINGLE; dec_o.e1 = 5'sd2;
    end else if ((t1_i == 8'd1 || t1_i == 8'd106) && t2_i == 8'd106) begin
      dec_o.code = 8'd112; dec_o.mode = MODE_LAYER; dec_o.e1 = 5'sd2; dec_o.e2 = 5'sd2;
    end else if (t1_i == 8'd107 && t2_i == TypeNone) begin
      dec_o.code = 8'd113; dec_o.mode = MODE_SINGLE;
    end else if (t1_i == 8'd107 && t2_i == 8'd107) begin
      dec_o.code = 8'd114; dec_o.mode = MODE_ISEN;
    end else if (t1_i == 8'd108 && t2_i == TypeNone) begin
      dec_o.code = 8'd115; dec_o.mode = MODE_SINGLE; dec_o.e1 = -5'sd2;
    end else if (t1_i == 8'd108 && t2_i == 8'd108) begin
      dec_o.code = 8'd116; dec_o.mode = MODE_LAYER; dec_o.e1 = -5'sd2; dec_o.e2 = -5'sd2;
    end else if (t1_i == 8'd109 && t2_i == TypeNone) begin
      dec_o.code = 8'd117; dec_o.mode = MODE_PV; dec_o.e1 = 5'sd9;
    end else if (t1_i == 8'd111 && t2_i == TypeNone) begin
      dec_o.code = 8'd119; dec_o.mode = MODE_SINGLE; dec_o.e1 = 5'sd4;
    end else if (t1_i == 8'd111 && t2_i == 8'd111) begin
      dec_o.code = 8'd120; dec_o.mode = MODE_LAYER; dec_o.e1 = 5'sd2; dec_o.e2 = 5'sd2;
    end else if (t1_i == 8'd160 && t2_i == TypeNone) begin
      dec_o.code = 8'd160; dec_o.mode = MODE_SINGLE;
    end else begin
      dec_o.code = CodeBad; dec_o.mode = MODE_BAD;
    end
  end

endmodule

### design/g2g1lvl_lane.sv
module g2g1lvl_lane #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                               clk_i,
  input  g2g1lvl_pkg::lane_t                 ctl_i,
  input  logic [g2g1lvl_pkg::MagW-1:0]       mag_i,
  output logic signed [VALUE_BITS-1:0]       value_o
);
  import g2g1lvl_pkg::*;

  localparam logic [63:0] HiLim = 64'({(VALUE_BITS-1){1'b1}});
  localparam logic signed [VALUE_BITS-1:0] MinVal = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // stage 2: first multiply, by 10^a or by a reciprocal
  lane_t        ctl2_q;
  logic [31:0]  mag2_q;
  logic [29:0]  coef2;
  logic [61:0]  p2_d, p2_q;

  assign coef2 = ctl_i.up ? pow10(ctl_i.a) : {1'b0, recip10(ctl_i.a)};
  assign p2_d  = {30'd0, mag_i} * {32'd0, coef2};

  always_ff @(posedge clk_i) begin
    ctl2_q <= ctl_i;
    mag2_q <= mag_i;
    p2_q   <= p2_d;
  end

  // stage 3: second multiply, by 10^b or quotient back by 10^a
  lane_t        ctl3_q;
  logic [31:0]  mag3_q;
  logic [33:0]  a3;
  logic [29:0]  b3;
  logic [63:0]  prod3;
  logic [63:0]  val3_d, val3_q;
  logic [29:0]  q03_q;
  logic         sat3_d, sat3_q;

  assign a3     = ctl2_q.up ? p2_q[33:0] : {4'd0, p2_q[61:32]};
  assign b3     = ctl2_q.up ? pow10(ctl2_q.b) : pow10(ctl2_q.a);
  assign prod3  = {30'd0, a3} * {34'd0, b3};
  assign val3_d = (ctl2_q.up && ctl2_q.b == 4'd0) ? {2'b00, p2_q} : prod3;
  assign sat3_d = ctl2_q.up && (mag2_q != 32'd0) &&
                  (ctl2_q.huge || (ctl2_q.b != 4'd0 && p2_q[61:34] != 28'd0));

  always_ff @(posedge clk_i) begin
    ctl3_q <= ctl2_q;
    mag3_q <= mag2_q;
    val3_q <= val3_d;
    q03_q  <= p2_q[61:32];
    sat3_q <= sat3_d;
  end

  // stage 4: quotient correction and half test
  lane_t        ctl4_q;
  logic [29:0]  d4;
  logic [31:0]  r0;
  logic [32:0]  r0x2, d33, d3x;
  logic         ge;
  logic [63:0]  q4_d, q4_q;
  logic         half4_d, half4_q, sat4_q;

  assign d4   = pow10(ctl3_q.a);
  assign r0   = mag3_q - val3_q[31:0];
  assign r0x2 = {r0, 1'b0};
  assign d33  = {3'd0, d4};
  assign d3x  = {3'd0, d4} + {2'd0, d4, 1'b0};
  assign ge   = r0 >= {2'd0, d4};

  always_comb begin
    if (ctl3_q.up) begin
      q4_d    = val3_q;
      half4_d = 1'b0;
    end else if (ctl3_q.far) begin
      q4_d    = 64'd0;
      half4_d = 1'b0;
    end else begin
      q4_d    = 64'(q03_q) + 64'(ge);
      half4_d = ge ? (r0x2 >= d3x) : (r0x2 >= d33);
    end
  end

  always_ff @(posedge clk_i) begin
    ctl4_q  <= ctl3_q;
    q4_q    <= q4_d;
    half4_q <= half4_d;
    sat4_q  <= sat3_q;
  end

  // stage 5: rounding toward zero after the half, then clamp
  logic [63:0]                  res5;
  logic                         over5;
  logic signed [VALUE_BITS-1:0] value5_d;

  always_comb begin
    if (!ctl4_q.neg || ctl4_q.sym) begin
      res5 = q4_q + 64'(half4_q);
    end else if (half4_q) begin
      res5 = q4_q;
    end else if (q4_q != 64'd0) begin
      res5 = q4_q - 64'd1;
    end else begin
      res5 = 64'd0;
    end
    over5 = sat4_q || (res5 > HiLim);
    if (!ctl4_q.neg) begin
      value5_d = over5 ? VALUE_BITS'(HiLim) : VALUE_BITS'(res5);
    end else begin
      value5_d = over5 ? MinVal : VALUE_BITS'(64'd0 - res5);
    end
  end

  always_ff @(posedge clk_i) begin
    value_o <= value5_d;
  end

endmodule

### design/grib2_to_grib1_level_map_core.sv
// grib2 to grib1 level mapping, fully pipelined
//
// a request is taken at any rising edge where start_i is high; busy_o is
// always low, so a new request may follow in every cycle. each request gives
// exactly one result, shown for one cycle with done_o high. results leave
// in request order.
//
// stages: decode and exponent prep, multiply by 10^a or a reciprocal,
// second multiply (10^b or quotient check), quotient correction and half
// test, rounding and clamp, level combine (isentropic 475 minus), then
// octet split and status into the output register.
//
// the receiver cannot hold a result off, so nothing stalls.
// reset clears the valid pipeline: no strobe follows reset until a new
// request has gone through.
`include "grib2_to_grib1_level_map_core_defines.svh"

module grib2_to_grib1_level_map_core #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [7:0]         first_type_i,
  input  logic signed [7:0]  first_scale_i,
  input  logic signed [31:0] first_value_i,
  input  logic [7:0]         second_type_i,
  input  logic signed [7:0]  second_scale_i,
  input  logic signed [31:0] second_value_i,
  output logic               done_o,
  output logic [7:0]         level_code_o,
  output logic signed [31:0] level_high_o,
  output logic signed [31:0] level_low_o,
  output logic [1:0]         status_o
);
  import g2g1lvl_pkg::*;

  localparam int unsigned Latency = 7;
  localparam logic signed [VALUE_BITS:0]   HiS     = {2'b00, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS:0]   C475    = (VALUE_BITS+1)'(475);
  localparam logic signed [VALUE_BITS:0]   IsenLim = C475 - HiS;
  localparam logic signed [VALUE_BITS-1:0] Oct     = VALUE_BITS'(255);

  // never stalls
  assign busy_o = 1'b0;

  // stage 1: decode the type pair and prepare both lanes
  dec_t        dec;
  logic        raw_s1, pv_s1;
  lane_t       ctl_a_d, ctl_a_q, ctl_b_d, ctl_b_q;
  logic [31:0] mag_a_d, mag_a_q, mag_b_d, mag_b_q;

  g2g1lvl_decode u_decode (
    .t1_i  (first_type_i),
    .t2_i  (second_type_i),
    .dec_o (dec)
  );

  assign raw_s1  = dec.mode == MODE_RAW;
  assign pv_s1   = dec.mode == MODE_PV;
  // hybrid passes raw, so it sees no scale
  assign ctl_a_d = lane_prep(dec.e1, raw_s1 ? 8'sd0 : first_scale_i,
                             raw_s1 || pv_s1, first_value_i[31]);
  assign ctl_b_d = lane_prep(dec.e2, second_scale_i, 1'b0, second_value_i[31]);
  assign mag_a_d = first_value_i[31] ? (32'd0 - $unsigned(first_value_i))
                                     : $unsigned(first_value_i);
  assign mag_b_d = second_value_i[31] ? (32'd0 - $unsigned(second_value_i))
                                      : $unsigned(second_value_i);

  always_ff @(posedge clk_i) begin
    ctl_a_q <= ctl_a_d;
    ctl_b_q <= ctl_b_d;
    mag_a_q <= mag_a_d;
    mag_b_q <= mag_b_d;
  end

  // code and mode travel beside the lanes, stage 1 to stage 6
  logic [7:0] code_q [6];
  mode_e      mode_q [6];

  always_ff @(posedge clk_i) begin
    code_q[0] <= dec.code;
    mode_q[0] <= dec.mode;
    for (int i = 1; i < 6; i++) begin
      code_q[i] <= code_q[i-1];
      mode_q[i] <= mode_q[i-1];
    end
  end

  // valid bits, stage 1 to stage 6
  logic [5:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], start_i};
    end
  end

  // stages 2 to 5: scaling lanes
  logic signed [VALUE_BITS-1:0] val_a, val_b;

  g2g1lvl_lane #(.VALUE_BITS(VALUE_BITS)) u_lane_a (
    .clk_i   (clk_i),
    .ctl_i   (ctl_a_q),
    .mag_i   (mag_a_q),
    .value_o (val_a)
  );

  g2g1lvl_lane #(.VALUE_BITS(VALUE_BITS)) u_lane_b (
    .clk_i   (clk_i),
    .ctl_i   (ctl_b_q),
    .mag_i   (mag_b_q),
    .value_o (val_b)
  );

  // stage 6: place the lane values into the two levels
  function automatic logic signed [VALUE_BITS-1:0] minus475(
      logic signed [VALUE_BITS-1:0] x);
    logic signed [VALUE_BITS:0] xe;
    logic signed [VALUE_BITS:0] diff;
    xe   = (VALUE_BITS+1)'(x);
    diff = C475 - xe;
    return (xe < IsenLim) ? HiS[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
  endfunction

  logic signed [VALUE_BITS-1:0] hi6_d, hi6_q, lo6_d, lo6_q;

  always_comb begin
    case (mode_q[4])
      MODE_SINGLE, MODE_RAW, MODE_PV: begin
        hi6_d = '0;
        lo6_d = val_a;
      end
      MODE_LAYER: begin
        hi6_d = val_a;
        lo6_d = val_b;
      end
      MODE_ISEN: begin
        hi6_d = minus475(val_a);
        lo6_d = minus475(val_b);
      end
      default: begin
        hi6_d = '0;
        lo6_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    hi6_q <= hi6_d;
    lo6_q <= lo6_d;
  end

  // stage 7: split a lone large low octet, then range status
  logic signed [VALUE_BITS-1:0] hi7, lo7;
  logic [1:0]                   st7;

  always_comb begin
    if (lo6_q > Oct && hi6_q == '0) begin
      hi7 = lo6_q >>> 8;
      lo7 = lo6_q & Oct;
    end else begin
      hi7 = hi6_q;
      lo7 = lo6_q;
    end
    if (mode_q[5] == MODE_BAD) begin
      st7 = ST_BAD;
    end else if (hi7 > Oct || lo7 > Oct) begin
      st7 = ST_RANGE;
    end else begin
      st7 = ST_OK;
    end
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    level_code_o <= code_q[5];
    level_high_o <= 32'(hi7);
    level_low_o  <= 32'(lo7);
    status_o     <= st7;
  end

  assign done_o = done_q;

  `G2G1_ASSERT_LAT(a_latency, clk_i, rst_ni, start_i && !busy_o, Latency, done_o, "request lost in pipeline")
  `G2G1_ASSERT_IMP(a_no_spurious, clk_i, rst_ni, done_o, $past(start_i, Latency), "result without request")
  `G2G1_ASSERT_IMP(a_bad_zero, clk_i, rst_ni, done_o && status_o == ST_BAD, level_code_o == CodeBad && level_high_o == 32'sd0 && level_low_o == 32'sd0, "unsupported pair not zeroed")

endmodule

### dv/grib2_to_grib1_level_map_core_tb.sv
module grib2_to_grib1_level_map_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import g2g1lvl_pkg::*;

  // one converted request: code, two octets and status
  typedef struct packed {
    logic [7:0]         code;
    logic signed [31:0] high;
    logic signed [31:0] low;
    logic [1:0]         status;
  } level_t;

  // one stimulus row; chk set where the answer is typed in by hand
  typedef struct {
    logic [7:0]         t1;
    logic signed [7:0]  s1;
    logic signed [31:0] v1;
    logic [7:0]         t2;
    logic signed [7:0]  s2;
    logic signed [31:0] v2;
    bit                 chk;
    level_t             want;
  } row_t;

  localparam int unsigned VB = 32;
  localparam int NRand = 1050;
  localparam longint CycleLimit = 200000;
  localparam int Latency = 7;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [7:0]         first_type_i;
  logic signed [7:0]  first_scale_i;
  logic signed [31:0] first_value_i;
  logic [7:0]         second_type_i;
  logic signed [7:0]  second_scale_i;
  logic signed [31:0] second_value_i;
  logic               done_o;
  logic [7:0]         level_code_o;
  logic signed [31:0] level_high_o;
  logic signed [31:0] level_low_o;
  logic [1:0]         status_o;

  level_t pending_levels[$];
  int     n_mismatch;
  longint cycles;
  int     sender_idle_pct;

  grib2_to_grib1_level_map_core #(.VALUE_BITS(VB)) dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .first_type_i, .first_scale_i, .first_value_i,
    .second_type_i, .second_scale_i, .second_value_i,
    .done_o, .level_code_o, .level_high_o, .level_low_o, .status_o
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // saturate a magnitude with sign to the value width
  function automatic longint sat_mag(bit neg, logic [63:0] mag);
    logic [63:0] hi;
    hi = (64'd1 << (VB - 1)) - 1;
    if (!neg) return (mag > hi) ? longint'(hi) : longint'(mag);
    if (mag > hi) return -longint'(hi) - 1;
    return -longint'(mag);
  endfunction

  function automatic longint sat_val(longint v);
    if (v < 0) return sat_mag(1'b1, 64'd0 - 64'(v));
    return sat_mag(1'b0, 64'(v));
  endfunction

  // exact v * 10^k with half-up rounding, truncated toward zero
  function automatic longint pow10_round(longint v, int k, bit sym);
    bit          neg, half;
    logic [63:0] mag, q, r, d, res;
    int          m;
    neg = v < 0;
    mag = neg ? 64'd0 - 64'(v) : 64'(v);
    r = 0;
    d = 1;
    if (k >= 0) begin
      q = mag;
      for (int i = 0; i < k; i++) begin
        if (q > 64'hFFFF_FFFF_FFFF_FFFF / 10) begin
          q = 64'hFFFF_FFFF_FFFF_FFFF;
          break;
        end
        q = q * 10;
      end
    end else begin
      m = (-k > 19) ? 19 : -k;
      for (int i = 0; i < m; i++) d = d * 10;
      q = mag / d;
      r = mag % d;
    end
    half = (r >= d - r) && (r != 0) && (d != 1);
    if (!neg || sym) res = q + (half ? 1 : 0);
    else res = half ? q : (q != 0 ? q - 1 : 0);
    return sat_mag(neg, res);
  endfunction

  // isentropic layer: 475 minus the level, saturating
  function automatic longint isentrope_from(longint v);
    longint hi;
    hi = (longint'(1) << (VB - 1)) - 1;
    if (v < 475 - hi) return hi;
    return sat_val(475 - v);
  endfunction

  function automatic level_t convert_levels(logic [7:0] t1, logic signed [7:0] s1,
                                            logic signed [31:0] v1, logic [7:0] t2,
                                            logic signed [7:0] s2,
                                            logic signed [31:0] v2);
    level_t r;
    mode_e  md;
    int     e1, e2;
    longint hi, lo;
    r.code = CodeBad;
    r.status = ST_OK;
    md = MODE_ZERO;
    e1 = 0;
    e2 = 0;
    hi = 0;
    lo = 0;
    if (t1 == 10 && t2 == TypeNone) r.code = 200;
    else if (t1 < 100 && t2 == TypeNone) r.code = t1;
    else if ((t1 == 1 || t1 == 2) && t2 == 8) r.code = t1;
    else if (t1 >= 200 && t2 == TypeNone) r.code = t1;
    else if (t1 == 100 && t2 == TypeNone) begin r.code = 100; md = MODE_SINGLE; e1 = -2; end
    else if (t1 == 100 && t2 == 100) begin
      r.code = 101; md = MODE_LAYER; e1 = -3; e2 = -3;
    end
    else if (t1 == 101 && t2 == TypeNone) r.code = 102;
    else if (t1 == 102 && t2 == TypeNone) begin r.code = 103; md = MODE_SINGLE; end
    else if (t1 == 102 && t2 == 102) begin
      r.code = 104; md = MODE_LAYER; e1 = -2; e2 = -2;
    end
    else if (t1 == 103 && t2 == TypeNone) begin r.code = 105; md = MODE_SINGLE; end
    else if (t1 == 103 && t2 == 103) begin
      r.code = 106; md = MODE_LAYER; e1 = -2; e2 = -2;
    end
    else if (t1 == 104 && t2 == TypeNone) begin r.code = 107; md = MODE_SINGLE; e1 = 4; end
    else if (t1 == 104 && t2 == 104) begin
      r.code = 108; md = MODE_LAYER; e1 = 2; e2 = 2;
    end
    else if (t1 == 105 && t2 == TypeNone) begin r.code = 109; md = MODE_RAW; end
    else if (t1 == 105 && t2 == 105) begin r.code = 110; md = MODE_LAYER; end
    else if (t1 == 106 && t2 == TypeNone) begin r.code = 111; md = MODE_SINGLE; e1 = 2; end
    else if ((t1 == 1 || t1 == 106) && t2 == 106) begin
      r.code = 112; md = MODE_LAYER; e1 = 2; e2 = 2;
    end
    else if (t1 == 107 && t2 == TypeNone) begin r.code = 113; md = MODE_SINGLE; end
    else if (t1 == 107 && t2 == 107) begin r.code = 114; md = MODE_ISEN; end
    else if (t1 == 108 && t2 == TypeNone) begin r.code = 115; md = MODE_SINGLE; e1 = -2; end
    else if (t1 == 108 && t2 == 108) begin
      r.code = 116; md = MODE_LAYER; e1 = -2; e2 = -2;
    end
    else if (t1 == 109 && t2 == TypeNone) begin r.code = 117; md = MODE_PV; e1 = 9; end
    else if (t1 == 111 && t2 == TypeNone) begin r.code = 119; md = MODE_SINGLE; e1 = 4; end
    else if (t1 == 111 && t2 == 111) begin
      r.code = 120; md = MODE_LAYER; e1 = 2; e2 = 2;
    end
    else if (t1 == 160 && t2 == TypeNone) begin r.code = 160; md = MODE_SINGLE; end
    else begin r.code = CodeBad; md = MODE_BAD; end

    case (md)
      MODE_SINGLE: lo = pow10_round(v1, e1 - int'(s1), 1'b0);
      MODE_LAYER: begin
        hi = pow10_round(v1, e1 - int'(s1), 1'b0);
        lo = pow10_round(v2, e2 - int'(s2), 1'b0);
      end
      MODE_RAW: lo = sat_val(v1);
      MODE_ISEN: begin
        hi = isentrope_from(pow10_round(v1, -int'(s1), 1'b0));
        lo = isentrope_from(pow10_round(v2, -int'(s2), 1'b0));
      end
      MODE_PV: lo = pow10_round(v1, e1 - int'(s1), 1'b1);
      MODE_BAD: r.status = ST_BAD;
      default: ;
    endcase
    if (md != MODE_BAD) begin
      // lone low octet above 255 is split into two bytes
      if (lo > 255 && hi == 0) begin
        hi = lo / 256;
        lo = lo % 256;
      end
      if (hi > 255 || lo > 255) r.status = ST_RANGE;
    end
    r.high = hi[31:0];
    r.low = lo[31:0];
    return r;
  endfunction

  function automatic row_t mk(logic [7:0] t1, logic signed [7:0] s1,
                              logic signed [31:0] v1, logic [7:0] t2,
                              logic signed [7:0] s2, logic signed [31:0] v2);
    row_t r;
    r.t1 = t1; r.s1 = s1; r.v1 = v1;
    r.t2 = t2; r.s2 = s2; r.v2 = v2;
    r.chk = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t mkw(logic [7:0] t1, logic signed [7:0] s1,
                               logic signed [31:0] v1, logic [7:0] t2,
                               logic signed [7:0] s2, logic signed [31:0] v2,
                               level_t w);
    row_t r;
    r = mk(t1, s1, v1, t2, s2, v2);
    r.chk = 1'b1;
    r.want = w;
    return r;
  endfunction

  // type codes that hit table rows, plus near misses
  function automatic logic [7:0] pick_type();
    logic [7:0] known[20];
    known = '{1, 2, 10, 100, 101, 102, 103, 104, 105, 106,
              107, 108, 109, 111, 160, 200, 255, 110, 8, 99};
    return known[$urandom_range(19)];
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh7FFF_FFFF - $urandom_range(3);
      2: return 32'sh8000_0000 + $urandom_range(3);
      3: return -$signed({1'b0, 31'($urandom_range(2000))});
      default: return $urandom_range(100000);
    endcase
  endfunction

  function automatic logic signed [7:0] pick_scale();
    case ($urandom_range(3))
      0: return $urandom;
      default: return $signed(8'($urandom_range(24))) - 8'sd12;
    endcase
  endfunction

  // send one request, waiting for acceptance; idle gaps first
  task automatic issue_request(row_t r);
    level_t w;
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    w = convert_levels(r.t1, r.s1, r.v1, r.t2, r.s2, r.v2);
    if (r.chk) w = r.want;
    start_i        <= 1'b1;
    first_type_i   <= r.t1;
    first_scale_i  <= r.s1;
    first_value_i  <= r.v1;
    second_type_i  <= r.t2;
    second_scale_i <= r.s2;
    second_value_i <= r.v2;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_levels.push_back(w);
  endtask

  // result checking against the oldest expectation
  always @(posedge clk_i) begin
    level_t got, w;
    if (rst_ni && done_o) begin
      got = '{level_code_o, level_high_o, level_low_o, status_o};
      if (pending_levels.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %p", got);
      end else begin
        w = pending_levels.pop_front();
        if (got !== w) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("mismatch: expected %p got %p", w, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    row_t   dir[$];
    row_t   r;
    int     ph;
    level_t ok0;
    n_mismatch = 0;
    cycles = 0;
    sender_idle_pct = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    first_type_i = '0;
    first_scale_i = '0;
    first_value_i = '0;
    second_type_i = '0;
    second_scale_i = '0;
    second_value_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    ok0 = '{8'd0, 32'sd0, 32'sd0, ST_OK};
    // directed rows: extremes and every table row
    dir.push_back(mkw(0, 0, 0, TypeNone, 0, 0, ok0));
    dir.push_back(mkw(TypeNone, 8'sh7F, 32'sh7FFF_FFFF, TypeNone, 8'sh81, 32'sh8000_0000,
                      '{CodeBad, 32'sd0, 32'sd0, ST_OK}));
    dir.push_back(mkw(10, 0, 5, TypeNone, 0, 0, '{8'd200, 32'sd0, 32'sd0, ST_OK}));
    // unsupported pair
    dir.push_back(mkw(110, 0, 1, 110, 0, 1, '{CodeBad, 32'sd0, 32'sd0, ST_BAD}));
    dir.push_back(mkw(0, 0, 0, 0, 0, 0, '{CodeBad, 32'sd0, 32'sd0, ST_BAD}));
    dir.push_back(mk(1, 0, 3, 8, 0, 0));
    dir.push_back(mk(2, 0, 3, 8, 0, 0));
    dir.push_back(mk(100, 0, 85000, TypeNone, 0, 0));
    dir.push_back(mk(100, 0, 50000, 100, 0, 85000));
    dir.push_back(mk(101, 0, 1, TypeNone, 0, 0));
    dir.push_back(mk(102, 0, 1500, TypeNone, 0, 0));
    dir.push_back(mk(102, 0, 100, 102, 0, 300));
    dir.push_back(mk(103, 1, 25, TypeNone, 0, 0));
    dir.push_back(mk(103, 0, 1000, 103, 0, 200));
    dir.push_back(mk(104, 4, 5000, TypeNone, 0, 0));
    dir.push_back(mk(104, 2, 50, 104, 2, 80));
    // hybrid raw value at the negative extreme, then the hybrid layer
    dir.push_back(mk(105, 0, 32'sh8000_0000, TypeNone, 0, 0));
    dir.push_back(mk(105, 0, 7, 105, 0, 9));
    dir.push_back(mk(106, 2, -150, TypeNone, 0, 0));
    dir.push_back(mk(1, 2, 10, 106, 2, 40));
    dir.push_back(mk(107, 0, 300, TypeNone, 0, 0));
    // isentropic layer with saturation on one side
    dir.push_back(mk(107, 0, 320, 107, 8'sh81, 32'sh8000_0000));
    dir.push_back(mk(108, 0, 7, TypeNone, 0, 0));
    dir.push_back(mk(108, 0, 7, 108, 0, 9));
    // potential vorticity, half way, both signs
    dir.push_back(mk(109, 8'sd10, -15, TypeNone, 0, 0));
    dir.push_back(mk(109, 8'sd10, 15, TypeNone, 0, 0));
    dir.push_back(mk(111, 0, 1, TypeNone, 0, 0));
    dir.push_back(mk(111, 8'sh80, -1, 111, 8'sh7F, 32'sh7FFF_FFFF));
    dir.push_back(mk(160, 8'sh81, 32'sh7FFF_FFFF, TypeNone, 0, 0));
    foreach (dir[i]) issue_request(dir[i]);

    // random phases: no idling, sender idle, receiver phase (cannot stall), both
    for (int n = 0; n < NRand; n++) begin
      ph = (n * 4) / NRand;
      sender_idle_pct = (ph == 1) ? 54 : ((ph == 3) ? 18 : 0);
      if ($urandom_range(9) < 7) begin
        r.t1 = pick_type();
        r.t2 = ($urandom_range(1)) ? TypeNone : r.t1;
        if ($urandom_range(19) == 0) r.t2 = pick_type();
      end else begin
        r.t1 = $urandom;
        r.t2 = $urandom;
      end
      r.s1 = pick_scale();
      r.s2 = pick_scale();
      r.v1 = pick_value();
      r.v2 = pick_value();
      r.chk = 1'b0;
      r.want = '0;
      issue_request(r);
    end
    start_i <= 1'b0;

    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    if (n_mismatch == 0 && pending_levels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
